// ===== rtl/nds_pkg.sv =====
// ----------------------------------------------------------------------------
// nds_pkg
// Shared types, constants and digit helpers of the nixie display sequencer.
// ----------------------------------------------------------------------------
package nds_pkg;

	localparam int FRAME_W       = 40;
	localparam int TUBE_W        = 10;
	localparam int HOUR_W        = 5;
	localparam int MINUTE_W      = 6;
	localparam int LAST_MINUTE_W = 7;
	localparam int CHANGES_W     = 9;
	localparam int POS_W         = 5;
	localparam int STEP_W        = 10;
	localparam int ELAPSED_W     = 17;
	localparam int IDLE_W        = 24;
	localparam int PERIOD_W      = 8;
	localparam int DURATION_W    = 16;
	localparam int TIMEOUT_W     = 8;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCOUNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [POS_W-1:0]         SWEEP_STEPS        = 5'd18;
	localparam logic [POS_W-1:0]         SWEEP_UP_STEPS     = 5'd10;
	localparam logic [IDLE_W-1:0]        MS_PER_MINUTE      = 24'd60000;
	localparam logic [LAST_MINUTE_W-1:0] NO_MINUTE          = 7'd100;
	localparam logic [PERIOD_W-1:0]      PERIOD_RESET       = 8'd15;
	localparam logic [DURATION_W-1:0]    DURATION_RESET     = 16'd3000;
	localparam logic [DURATION_W-1:0]    STARTUP_RESET      = 16'd2000;
	localparam logic [STEP_W-1:0]        STEP_RESET         = 10'd25;
	localparam logic [IDLE_W-1:0]        IDLE_LIMIT_RESET   = 24'd3600000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SWEEP_PERIOD     = 3'd0,
		REG_SWEEP_DURATION   = 3'd1,
		REG_STARTUP_DURATION = 3'd2,
		REG_SWEEP_STEP       = 3'd3,
		REG_IDLE_TIMEOUT     = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [HOUR_W-1:0]   hour_now;
		logic [MINUTE_W-1:0] minute_now;
		logic                motion_seen;
	} tick_t;

	typedef struct packed {
		logic [FRAME_W-1:0] digit_frame;
		logic               display_on;
		logic               sweeping;
	} result_t;

	// classified tick as it waits between front and back
	typedef struct packed {
		logic [FRAME_W-1:0]  time_frame;
		logic [MINUTE_W-1:0] minute_now;
		logic                motion_seen;
	} work_t;

	typedef struct packed {
		logic [2:0] tens;
		logic [3:0] units;
	} bcd_t;

	function automatic logic [TUBE_W-1:0] digit_onehot(input logic [3:0] d);
		digit_onehot = TUBE_W'(1) << d;
	endfunction

	// divide by ten through a reciprocal multiply, exact up to 63
	function automatic bcd_t bcd_split(input logic [MINUTE_W-1:0] v);
		logic [13:0] prod;
		bcd_t        r;
		prod    = 14'(v) * 14'd205;
		r.tens  = prod[13:11];
		r.units = 4'(v - 6'(r.tens) * 6'd10);
		bcd_split = r;
	endfunction

	function automatic logic [FRAME_W-1:0] time_frame(input logic [HOUR_W-1:0] hour,
		input logic [MINUTE_W-1:0] minute);
		bcd_t               h;
		bcd_t               m;
		logic [TUBE_W-1:0]  h_tens;
		h      = bcd_split(MINUTE_W'(hour));
		m      = bcd_split(minute);
		// hour tens tube stays blank below ten
		h_tens = (h.tens != 3'd0) ? digit_onehot(4'(h.tens)) : '0;
		time_frame = {digit_onehot(m.units), digit_onehot(4'(m.tens)),
			digit_onehot(h.units), h_tens};
	endfunction

	function automatic logic [FRAME_W-1:0] sweep_frame(input logic [POS_W-1:0] pos);
		logic [3:0]        d;
		logic [TUBE_W-1:0] oh;
		// count up 0..9, then back down 8..1
		d  = (pos < SWEEP_UP_STEPS) ? pos[3:0] : 4'(SWEEP_STEPS - pos);
		oh = digit_onehot(d);
		sweep_frame = {oh, oh, oh, oh};
	endfunction

endpackage

// ===== rtl/nds_if.sv =====
// ----------------------------------------------------------------------------
// nds_tick_if / nds_result_if
// Valid/ready channels carrying ticks into and results out of the sequencer.
// ----------------------------------------------------------------------------
interface nds_tick_if;
	import nds_pkg::*;
	logic  valid;
	logic  ready;
	tick_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nds_result_if;
	import nds_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/nds_front.sv =====
// ----------------------------------------------------------------------------
// nds_front
// Accepts ticks and splits the time into a one-hot BCD frame for the queue.
// ----------------------------------------------------------------------------
module nds_front (
	nds_tick_if.sink          tick,
	input  logic              q_full,
	output logic              q_push,
	output nds_pkg::work_t    q_wdata
);
	import nds_pkg::*;

	assign tick.ready = !q_full;
	assign q_push     = tick.valid && !q_full;

	always_comb begin
		q_wdata.time_frame  = time_frame(tick.data.hour_now, tick.data.minute_now);
		q_wdata.minute_now  = tick.data.minute_now;
		q_wdata.motion_seen = tick.data.motion_seen;
	end
endmodule

// ===== rtl/nds_queue.sv =====
// ----------------------------------------------------------------------------
// nds_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module nds_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  nds_pkg::work_t    wdata,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output nds_pkg::work_t    rdata
);
	import nds_pkg::*;

	work_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;

	assign full      = (count_q == QCOUNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== rtl/nds_back.sv =====
// ----------------------------------------------------------------------------
// nds_back
// Minute tracking, cathode sweep, idle timer and the registered result.
// ----------------------------------------------------------------------------
module nds_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [nds_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [nds_pkg::CFG_DATA_W-1:0]   wr_data,
	input  logic                             q_not_empty,
	input  nds_pkg::work_t                   q_rdata,
	output logic                             q_pop,
	nds_result_if.source                     result
);
	import nds_pkg::*;

	// configuration
	logic [PERIOD_W-1:0]   period_q;
	logic [DURATION_W-1:0] duration_q;
	logic [DURATION_W-1:0] startup_q;
	logic [STEP_W-1:0]     step_ms_q;
	logic [IDLE_W-1:0]     idle_limit_q;

	// sequencer state
	logic [LAST_MINUTE_W-1:0] last_minute_q;
	logic [CHANGES_W-1:0]     changes_q;
	logic                     active_q;
	logic                     startup_q_flag_q;
	logic [POS_W-1:0]         pos_q;
	logic [STEP_W-1:0]        step_q;
	logic [ELAPSED_W-1:0]     elapsed_q;
	logic [IDLE_W-1:0]        idle_q;
	logic                     disp_q;
	logic [FRAME_W-1:0]       frame_q;

	logic                     out_valid_q;
	result_t                  out_data_q;

	logic [LAST_MINUTE_W-1:0] last_minute_n;
	logic [CHANGES_W-1:0]     changes_n;
	logic                     active_n;
	logic                     startup_n;
	logic [POS_W-1:0]         pos_n;
	logic [STEP_W-1:0]        step_n;
	logic [ELAPSED_W-1:0]     elapsed_n;
	logic [IDLE_W-1:0]        idle_n;
	logic                     disp_n;
	logic [FRAME_W-1:0]       frame_n;
	result_t                  res_n;
	logic [CHANGES_W-1:0]     changes_inc;
	logic [DURATION_W-1:0]    limit;

	assign q_pop        = q_not_empty && (!out_valid_q || result.ready);
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	always_comb begin
		last_minute_n = last_minute_q;
		changes_n     = changes_q;
		active_n      = active_q;
		startup_n     = startup_q_flag_q;
		pos_n         = pos_q;
		step_n        = step_q;
		elapsed_n     = elapsed_q;
		idle_n        = idle_q;
		disp_n        = disp_q;
		frame_n       = frame_q;
		changes_inc   = changes_q + 1'b1;
		limit         = startup_q_flag_q ? startup_q : duration_q;

		if (!active_q && ({1'b0, q_rdata.minute_now} != last_minute_q)) begin
			frame_n       = q_rdata.time_frame;
			last_minute_n = {1'b0, q_rdata.minute_now};
			changes_n     = changes_inc;
			if (changes_inc == CHANGES_W'(period_q)) begin
				active_n  = 1'b1;
				startup_n = 1'b0;
				pos_n     = '0;
				step_n    = '0;
				elapsed_n = '0;
				changes_n = '0;
			end
		end

		if (!active_n) begin
			if (q_rdata.motion_seen) begin
				idle_n = '0;
				disp_n = 1'b1;
			end
			if (idle_n >= idle_limit_q) begin
				disp_n = 1'b0;
				idle_n = '0;
			end
		end

		res_n.digit_frame = active_n ? sweep_frame(pos_n) : frame_n;
		res_n.display_on  = disp_n;
		res_n.sweeping    = active_n;

		if (active_n) begin
			if (elapsed_n != '1) begin
				elapsed_n = elapsed_n + 1'b1;
			end
			if ({1'b0, step_n} + 11'd1 >= {1'b0, step_ms_q}) begin
				step_n = '0;
				pos_n  = pos_n + 1'b1;
				if (pos_n >= SWEEP_STEPS) begin
					pos_n = '0;
					// whole sweeps repeat until the elapsed time passes the limit
					if (elapsed_n > ELAPSED_W'(limit)) begin
						active_n = 1'b0;
						if (startup_n) begin
							disp_n    = 1'b1;
							startup_n = 1'b0;
						end
					end
				end
			end else begin
				step_n = step_n + 1'b1;
			end
		end

		if (idle_n != '1) begin
			idle_n = idle_n + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= PERIOD_RESET;
			duration_q   <= DURATION_RESET;
			startup_q    <= STARTUP_RESET;
			step_ms_q    <= STEP_RESET;
			idle_limit_q <= IDLE_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SWEEP_PERIOD:     period_q   <= wr_data[PERIOD_W-1:0];
				REG_SWEEP_DURATION:   duration_q <= wr_data[DURATION_W-1:0];
				REG_STARTUP_DURATION: startup_q  <= wr_data[DURATION_W-1:0];
				REG_SWEEP_STEP:       step_ms_q  <= wr_data[STEP_W-1:0];
				REG_IDLE_TIMEOUT: begin
					// keep the timeout as a tick count
					idle_limit_q <= IDLE_W'(wr_data[TIMEOUT_W-1:0]) * MS_PER_MINUTE;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_minute_q    <= NO_MINUTE;
			changes_q        <= '1;
			active_q         <= 1'b1;
			startup_q_flag_q <= 1'b1;
			pos_q            <= '0;
			step_q           <= '0;
			elapsed_q        <= '0;
			idle_q           <= '0;
			disp_q           <= 1'b0;
			frame_q          <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (q_pop) begin
				last_minute_q    <= last_minute_n;
				changes_q        <= changes_n;
				active_q         <= active_n;
				startup_q_flag_q <= startup_n;
				pos_q            <= pos_n;
				step_q           <= step_n;
				elapsed_q        <= elapsed_n;
				idle_q           <= idle_n;
				disp_q           <= disp_n;
				frame_q          <= frame_n;
				out_valid_q      <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_data_q <= res_n;
		end
	end
endmodule

// ===== rtl/nixie_display_sequencer.sv =====
// ----------------------------------------------------------------------------
// nixie_display_sequencer
// Millisecond-tick driven nixie frame generator with cathode sweeps and idle off.
// ----------------------------------------------------------------------------
// a tick request is written into the queue, then popped into the back's registered result
// throughput: one tick per cycle unless the result output stalls, set by the state update in the back
// a four-entry queue lets the front keep taking ticks while a result is stalled, until the queue fills
// reset: queue and output empty, registers at defaults, startup sweep pending
module nixie_display_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [nds_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [nds_pkg::CFG_DATA_W-1:0]   wr_data,
	nds_tick_if.sink                         tick,
	nds_result_if.source                     result
);
	import nds_pkg::*;

	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_not_empty;
	work_t q_wdata;
	work_t q_rdata;

	nds_front u_front (
		.tick    (tick),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	nds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	nds_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.q_not_empty (q_not_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.result      (result)
	);
endmodule

// ===== sim/nixie_display_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// nixie_display_sequencer_test
// Drives millisecond ticks into the sequencer and checks every frame against
// a cycle-free model of the digit latch, cathode sweeps and idle switch-off.
// ----------------------------------------------------------------------------
module nixie_display_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import nds_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int REPORT_LIMIT = 10;

	logic                   clk;
	logic                   arst_n;
	logic                   wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0]  wr_data;

	nds_tick_if   tick_ch();
	nds_result_if result_ch();

	nixie_display_sequencer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.tick     (tick_ch),
		.result   (result_ch)
	);

	// register copies
	logic [PERIOD_W-1:0]   cfg_period;
	logic [DURATION_W-1:0] cfg_duration;
	logic [DURATION_W-1:0] cfg_startup;
	logic [STEP_W-1:0]     cfg_step;
	logic [TIMEOUT_W-1:0]  cfg_idle_min;

	// sequencer state as the display should see it
	logic [LAST_MINUTE_W-1:0] prev_minute;
	logic [CHANGES_W-1:0]     change_count;
	logic                     in_sweep;
	logic                     startup_pass;
	logic [POS_W-1:0]         sweep_pos;
	logic [STEP_W-1:0]        step_count;
	logic [ELAPSED_W-1:0]     elapsed_ms;
	logic [IDLE_W-1:0]        idle_ms;
	logic                     supply_on;
	logic [FRAME_W-1:0]       latched_frame;

	result_t     pending_displays[$];
	int unsigned fault_count = 0;
	int          burst_left  = 0;
	int          hold_left   = 0;
	int          quiet_cycles = 0;
	logic [HOUR_W-1:0]   stim_hour;
	logic [MINUTE_W-1:0] stim_minute;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void reset_display_model();
		cfg_period    = PERIOD_RESET;
		cfg_duration  = DURATION_RESET;
		cfg_startup   = STARTUP_RESET;
		cfg_step      = STEP_RESET;
		cfg_idle_min  = TIMEOUT_W'(60);
		prev_minute   = NO_MINUTE;
		change_count  = '1;
		in_sweep      = 1'b1;
		startup_pass  = 1'b1;
		sweep_pos     = '0;
		step_count    = '0;
		elapsed_ms    = '0;
		idle_ms       = '0;
		supply_on     = 1'b0;
		latched_frame = '0;
	endfunction

	function automatic logic [FRAME_W-1:0] clock_face(input logic [HOUR_W-1:0] hour,
		input logic [MINUTE_W-1:0] minute);
		int unsigned        hu;
		int unsigned        mu;
		logic [FRAME_W-1:0] f;
		hu = hour;
		mu = minute;
		f  = '0;
		// hour tens tube dark below ten
		if (hu >= 10)
			f[hu / 10] = 1'b1;
		f[TUBE_W + hu % 10]     = 1'b1;
		f[2 * TUBE_W + mu / 10] = 1'b1;
		f[3 * TUBE_W + mu % 10] = 1'b1;
		return f;
	endfunction

	function automatic logic [FRAME_W-1:0] sweep_face(input logic [POS_W-1:0] pos);
		int unsigned        d;
		logic [FRAME_W-1:0] f;
		d = (pos < SWEEP_UP_STEPS) ? pos : SWEEP_STEPS - pos;
		f = '0;
		for (int k = 0; k < 4; k++)
			f[k * TUBE_W + d] = 1'b1;
		return f;
	endfunction

	// one millisecond of the sequencer: latch, motion, output, sweep advance
	function automatic result_t compute_display(input tick_t t);
		result_t     r;
		int unsigned idle_limit;
		int unsigned repeat_limit;
		if (!in_sweep && {1'b0, t.minute_now} != prev_minute) begin
			latched_frame = clock_face(t.hour_now, t.minute_now);
			prev_minute   = {1'b0, t.minute_now};
			change_count  = change_count + 1'b1;
			if (change_count == {1'b0, cfg_period}) begin
				in_sweep     = 1'b1;
				startup_pass = 1'b0;
				sweep_pos    = '0;
				step_count   = '0;
				elapsed_ms   = '0;
				change_count = '0;
			end
		end
		if (!in_sweep) begin
			if (t.motion_seen) begin
				idle_ms   = '0;
				supply_on = 1'b1;
			end
			idle_limit = cfg_idle_min * MS_PER_MINUTE;
			if (idle_ms >= idle_limit) begin
				supply_on = 1'b0;
				idle_ms   = '0;
			end
		end
		r.digit_frame = in_sweep ? sweep_face(sweep_pos) : latched_frame;
		r.display_on  = supply_on;
		r.sweeping    = in_sweep;
		if (in_sweep) begin
			if (elapsed_ms != '1)
				elapsed_ms = elapsed_ms + 1'b1;
			if ({1'b0, step_count} + 11'd1 >= {1'b0, cfg_step}) begin
				step_count = '0;
				sweep_pos  = sweep_pos + 1'b1;
				if (sweep_pos >= SWEEP_STEPS) begin
					repeat_limit = startup_pass ? cfg_startup : cfg_duration;
					sweep_pos    = '0;
					if (elapsed_ms > repeat_limit) begin
						in_sweep = 1'b0;
						if (startup_pass) begin
							supply_on    = 1'b1;
							startup_pass = 1'b0;
						end
					end
				end
			end else begin
				step_count = step_count + 1'b1;
			end
		end
		if (idle_ms != '1)
			idle_ms = idle_ms + 1'b1;
		return r;
	endfunction

	task automatic send_tick(input logic [HOUR_W-1:0] hour, input logic [MINUTE_W-1:0] minute,
		input logic motion);
		int    gap;
		tick_t t;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if ($urandom_range(0, 15) == 0)
				gap = 16;
			if (gap > 0) begin
				tick_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		t.hour_now    = hour;
		t.minute_now  = minute;
		t.motion_seen = motion;
		tick_ch.valid <= 1'b1;
		tick_ch.data  <= t;
		do @(posedge clk); while (!tick_ch.ready);
		pending_displays.push_back(compute_display(t));
	endtask

	task automatic drain_displays();
		tick_ch.valid <= 1'b0;
		while (pending_displays.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SWEEP_PERIOD:     cfg_period   = value[PERIOD_W-1:0];
			REG_SWEEP_DURATION:   cfg_duration = value[DURATION_W-1:0];
			REG_STARTUP_DURATION: cfg_startup  = value[DURATION_W-1:0];
			REG_SWEEP_STEP:       cfg_step     = value[STEP_W-1:0];
			REG_IDLE_TIMEOUT:     cfg_idle_min = value[TIMEOUT_W-1:0];
			default: ;
		endcase
	endtask

	// change the minute every tick until a sweep starts, then ride it out
	task automatic run_sweep_cycle();
		logic [HOUR_W-1:0]   h;
		logic [MINUTE_W-1:0] m;
		h = HOUR_W'($urandom_range(0, 23));
		m = prev_minute[MINUTE_W-1:0];
		while (!in_sweep) begin
			do m = MINUTE_W'($urandom_range(0, 63)); while ({1'b0, m} == prev_minute);
			send_tick(h, m, 1'($urandom_range(0, 1)));
		end
		// minute and motion are not looked at while sweeping
		while (in_sweep)
			send_tick(h, MINUTE_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
		repeat (4)
			send_tick(h, m, 1'($urandom_range(0, 1)));
	endtask

	task automatic test_reset_defaults();
		repeat (60)
			send_tick(HOUR_W'($urandom_range(0, 23)), MINUTE_W'($urandom_range(0, 59)),
				1'($urandom_range(0, 1)));
		drain_displays();
		write_register(REG_SWEEP_STEP, 16'd2);
		write_register(REG_STARTUP_DURATION, 16'd20);
		write_register(REG_SWEEP_DURATION, 16'd40);
		// startup sweep stops at the end of the pass it is in
		run_sweep_cycle();
		// first periodic sweep on the reset period
		run_sweep_cycle();
	endtask

	task automatic test_digit_extremes();
		drain_displays();
		write_register(REG_SWEEP_PERIOD, 16'd255);
		write_register(REG_SWEEP_STEP, 16'd0);
		write_register(REG_SWEEP_DURATION, 16'd0);
		// zero timeout: supply drops on every tick outside a sweep
		write_register(REG_IDLE_TIMEOUT, 16'd0);
		send_tick(5'd0, 6'd0, 1'b1);
		send_tick(5'd9, 6'd59, 1'b1);
		send_tick(5'd10, 6'd0, 1'b0);
		send_tick(5'd19, 6'd9, 1'b1);
		send_tick(5'd23, 6'd59, 1'b0);
		send_tick(5'd31, 6'd63, 1'b1);
		send_tick(5'd16, 6'd32, 1'b0);
		send_tick(5'd24, 6'd40, 1'b1);
		send_tick(5'd24, 6'd40, 1'b0);
		send_tick(5'd1, 6'd31, 1'b1);
		drain_displays();
		write_register(REG_IDLE_TIMEOUT, 16'd1);
		send_tick(5'd12, 6'd0, 1'b1);
		send_tick(5'd12, 6'd0, 1'b0);
		send_tick(5'd12, 6'd0, 1'b0);
	endtask

	task automatic test_period_extremes();
		drain_displays();
		write_register(REG_SWEEP_STEP, 16'd1);
		write_register(REG_SWEEP_DURATION, 16'd0);
		// next minute change hits the period, the count restarts from zero
		write_register(REG_SWEEP_PERIOD, CFG_DATA_W'(change_count) + 16'd1);
		run_sweep_cycle();
		drain_displays();
		write_register(REG_SWEEP_PERIOD, 16'd1);
		run_sweep_cycle();
		drain_displays();
		write_register(REG_SWEEP_PERIOD, 16'd2);
		run_sweep_cycle();
	endtask

	task automatic test_step_extremes();
		logic [HOUR_W-1:0]   h;
		logic [MINUTE_W-1:0] m;
		h = HOUR_W'($urandom_range(0, 23));
		m = prev_minute[MINUTE_W-1:0];
		drain_displays();
		write_register(REG_SWEEP_STEP, 16'd1023);
		write_register(REG_SWEEP_DURATION, 16'd0);
		write_register(REG_SWEEP_PERIOD, 16'd1);
		while (!in_sweep) begin
			do m = MINUTE_W'($urandom_range(0, 63)); while ({1'b0, m} == prev_minute);
			send_tick(h, m, 1'($urandom_range(0, 1)));
		end
		// slowest step: the first digit holds
		repeat (40)
			send_tick(h, m, 1'($urandom_range(0, 1)));
		drain_displays();
		// a shorter step time applies to the running sweep
		write_register(REG_SWEEP_STEP, 16'd1);
		run_sweep_cycle();
	endtask

	task automatic test_duration_extremes();
		drain_displays();
		write_register(REG_SWEEP_STEP, 16'd1);
		write_register(REG_SWEEP_PERIOD, 16'd1);
		write_register(REG_SWEEP_DURATION, 16'd35);
		run_sweep_cycle();
		drain_displays();
		// elapsed time equal to the limit still repeats the sweep
		write_register(REG_SWEEP_DURATION, 16'd36);
		run_sweep_cycle();
	endtask

	task automatic test_idle_timeout();
		logic [HOUR_W-1:0] h;
		h = HOUR_W'($urandom_range(0, 31));
		drain_displays();
		write_register(REG_IDLE_TIMEOUT, 16'd1);
		write_register(REG_SWEEP_PERIOD, 16'd255);
		send_tick(h, prev_minute[MINUTE_W-1:0], 1'b1);
		repeat (5)
			send_tick(h, prev_minute[MINUTE_W-1:0], 1'b0);
		drain_displays();
		// zero timeout drops the supply even on a motion tick
		write_register(REG_IDLE_TIMEOUT, 16'd0);
		send_tick(h, prev_minute[MINUTE_W-1:0], 1'b1);
		send_tick(h, prev_minute[MINUTE_W-1:0], 1'b0);
		drain_displays();
		write_register(REG_IDLE_TIMEOUT, 16'd255);
		repeat (20)
			send_tick(h, prev_minute[MINUTE_W-1:0], 1'($urandom_range(0, 1)));
	endtask

	task automatic test_random_traffic();
		logic motion;
		stim_hour   = 5'd23;
		stim_minute = 6'd55;
		motion      = 1'b0;
		for (int round = 0; round < 4; round++) begin
			drain_displays();
			write_register(REG_SWEEP_PERIOD, CFG_DATA_W'($urandom_range(1, 6)));
			write_register(REG_SWEEP_STEP, CFG_DATA_W'($urandom_range(0, 4)));
			write_register(REG_SWEEP_DURATION, CFG_DATA_W'($urandom_range(0, 120)));
			write_register(REG_IDLE_TIMEOUT, (round == 0) ? CFG_DATA_W'(0) :
				CFG_DATA_W'($urandom_range(1, 255)));
			for (int i = 0; i < 90; i++) begin
				if ($urandom_range(0, 5) == 0)
					motion = ~motion;
				if ($urandom_range(0, 6) == 0) begin
					// garbage time, out of range included
					send_tick(HOUR_W'($urandom_range(0, 31)), MINUTE_W'($urandom_range(0, 63)),
						1'($urandom_range(0, 1)));
				end else begin
					if ($urandom_range(0, 7) == 0) begin
						stim_minute = stim_minute + 1'b1;
						if (stim_minute == 6'd60) begin
							stim_minute = '0;
							stim_hour   = (stim_hour == 5'd23) ? 5'd0 : stim_hour + 1'b1;
						end
					end
					send_tick(stim_hour, stim_minute, motion);
				end
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (pending_displays.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected result: frame %h display_on %b sweeping %b",
						got.digit_frame, got.display_on, got.sweeping);
			end else begin
				want = pending_displays.pop_front();
				if (got.digit_frame !== want.digit_frame || got.display_on !== want.display_on ||
					got.sweeping !== want.sweeping) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("mismatch at %0t: frame %h on %b sweep %b, expected %h on %b sweep %b",
							$realtime, got.digit_frame, got.display_on, got.sweeping,
							want.digit_frame, want.display_on, want.sweeping);
				end
			end
		end
	end

	// receiver: runs of ready broken by short stalls and now and then a long one
	always @(posedge clk) begin
		if (hold_left == 0) begin
			if (result_ch.ready) begin
				result_ch.ready <= 1'b0;
				hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) :
					$urandom_range(1, 3);
			end else begin
				result_ch.ready <= 1'b1;
				hold_left <= $urandom_range(1, 50);
			end
		end else begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no request accepted for %0d cycles", quiet_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = '0;
		wr_data         = '0;
		tick_ch.valid   = 1'b0;
		tick_ch.data    = '0;
		result_ch.ready = 1'b0;
		reset_display_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_digit_extremes();
		test_period_extremes();
		test_step_extremes();
		test_duration_extremes();
		test_idle_timeout();
		test_random_traffic();
		drain_displays();
		repeat (8) @(posedge clk);
		fault_count += pending_displays.size();
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
